FILE: rtl/core/top_n_sorted_insert_table_top_defines.svh
// Assertion macros shared by the checker of the sorted insertion table.
`ifndef TOP_N_SORTED_INSERT_TABLE_TOP_DEFINES_SVH
`define TOP_N_SORTED_INSERT_TABLE_TOP_DEFINES_SVH

// Checks that the consequent holds in the cycle after the antecedent.
`define NSIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nsit: next-cycle check failed");

// Checks that the consequent holds in the same cycle as the antecedent.
`define NSIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nsit: same-cycle check failed");

`endif

FILE: rtl/core/nsit_pkg.sv
// Types and constants of the sorted insertion table.
package nsit_pkg;

  // Table size and field widths.
  localparam int ENTRIES     = 10;
  localparam int SCORE_W     = 16;
  localparam int TAG_W       = 24;
  localparam int INDEX_W     = 8;
  localparam int POS_W       = 6;

  // An empty slot shows three dashes and a zero score.
  localparam logic [7:0]       DASH_CHAR = 8'h2D;
  localparam logic [TAG_W-1:0] DASH_TAG  = {DASH_CHAR, DASH_CHAR, DASH_CHAR};

  // Command codes.
  typedef enum logic [0:0] {
    CMD_SUBMIT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  // What one cell hands to the cell below it.
  typedef struct packed {
    logic               ge;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } cell_link_t;

endpackage

FILE: rtl/core/nsit_cell.sv
// One slot of the sorted table: holds an entry, compares, and shifts.
module nsit_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      submit_i,
  input  logic [nsit_pkg::SCORE_W-1:0] new_score_i,
  input  logic [nsit_pkg::TAG_W-1:0]   new_tag_i,
  input  nsit_pkg::cell_link_t      prev_i,
  output nsit_pkg::cell_link_t      link_o
);

  logic [nsit_pkg::SCORE_W-1:0] score_q, score_d;
  logic [nsit_pkg::TAG_W-1:0]   tag_q, tag_d;
  logic                         ge;

  // The new score equals or beats this slot's score.
  assign ge = (new_score_i >= score_q);

  // A qualifying slot takes the entry from above if that one also
  // qualified, otherwise it is the insertion point and takes the new entry.
  always_comb begin
    score_d = score_q;
    tag_d   = tag_q;
    if (submit_i && ge) begin
      if (prev_i.ge) begin
        score_d = prev_i.score;
        tag_d   = prev_i.tag;
      end else begin
        score_d = new_score_i;
        tag_d   = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      tag_q   <= nsit_pkg::DASH_TAG;
    end else begin
      score_q <= score_d;
      tag_q   <= tag_d;
    end
  end

  assign link_o.ge    = ge;
  assign link_o.score = score_q;
  assign link_o.tag   = tag_q;

endmodule

FILE: rtl/core/top_n_sorted_insert_table_top.sv
// Top level of the sorted insertion table: a chain of slot cells.
//
// Usage: raise start with command_i, tag_chars_i, score_i and index_i; the
// transaction is taken at the rising edge where start is high and busy is
// low. busy stays low, so a new transaction may be given in every cycle.
// A submit inserts the entry above the first slot whose score it equals
// or beats; the lower entries move down one slot and the last one drops.
// A read returns the entry at index_i, or dashes and zero out of range.
// Every result also reports whether the score would qualify against the
// last slot as it stood before the transaction.
// The result appears with done_o in the cycle after acceptance; it is
// shown for exactly one cycle, and the receiver cannot stall it.
// Throughput: one transaction per cycle, since every cell compares and
// shifts in the same cycle. Reset empties the table at once: all scores
// zero, all tags three dashes; no result is pending after reset.
module top_n_sorted_insert_table_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [nsit_pkg::TAG_W-1:0]   tag_chars_i,
  input  logic [nsit_pkg::SCORE_W-1:0] score_i,
  input  logic [nsit_pkg::INDEX_W-1:0] index_i,
  output logic                         done_o,
  output logic                         inserted_o,
  output logic [nsit_pkg::POS_W-1:0]   insert_position_o,
  output logic                         qualifies_o,
  output logic [nsit_pkg::TAG_W-1:0]   read_tag_o,
  output logic [nsit_pkg::SCORE_W-1:0] read_score_o
);

  nsit_pkg::cell_link_t link [nsit_pkg::ENTRIES];
  nsit_pkg::cell_link_t top_link;
  logic                 accept;
  logic                 submit;
  logic                 is_read;

  logic                         done_q;
  logic                         inserted_q, inserted_d;
  logic [nsit_pkg::POS_W-1:0]   pos_q, pos_d;
  logic                         qual_q, qual_d;
  logic [nsit_pkg::TAG_W-1:0]   rtag_q, rtag_d;
  logic [nsit_pkg::SCORE_W-1:0] rscore_q, rscore_d;

  // The chain completes a transaction without stalling.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_read = (command_i == nsit_pkg::CMD_READ);
  assign submit  = accept && !is_read;

  // Above the first cell nothing qualifies.
  assign top_link = '{ge: 1'b0, score: '0, tag: nsit_pkg::DASH_TAG};

  // Row of slot cells, best entry in cell 0.
  for (genvar i = 0; i < nsit_pkg::ENTRIES; i++) begin : g_cell
    nsit_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .submit_i   (submit),
      .new_score_i(score_i),
      .new_tag_i  (tag_chars_i),
      .prev_i     ((i == 0) ? top_link : link[(i == 0) ? 0 : i - 1]),
      .link_o     (link[i])
    );
  end

  // Result fields. The table is sorted, so qualifying slots form a tail;
  // the last cell qualifying means the score qualifies at all.
  always_comb begin
    qual_d     = link[nsit_pkg::ENTRIES-1].ge;
    inserted_d = 1'b0;
    pos_d      = '0;
    rtag_d     = '0;
    rscore_d   = '0;
    if (is_read) begin
      rtag_d = nsit_pkg::DASH_TAG;
      for (int i = 0; i < nsit_pkg::ENTRIES; i++) begin
        if (index_i == nsit_pkg::INDEX_W'(i)) begin
          rtag_d   = link[i].tag;
          rscore_d = link[i].score;
        end
      end
    end else begin
      inserted_d = qual_d;
      // The insertion point is the one cell that qualifies below one that does not.
      for (int i = 0; i < nsit_pkg::ENTRIES; i++) begin
        if (link[i].ge && ((i == 0) || !link[(i == 0) ? 0 : i - 1].ge)) begin
          pos_d = pos_d | nsit_pkg::POS_W'(i);
        end
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  // Result payload, captured on acceptance.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      inserted_q <= inserted_d;
      pos_q      <= pos_d;
      qual_q     <= qual_d;
      rtag_q     <= rtag_d;
      rscore_q   <= rscore_d;
    end
  end

  assign done_o            = done_q;
  assign inserted_o        = inserted_q;
  assign insert_position_o = pos_q;
  assign qualifies_o       = qual_q;
  assign read_tag_o        = rtag_q;
  assign read_score_o      = rscore_q;

endmodule

FILE: rtl/core/nsit_checker.sv
// Port-level checks of the sorted insertion table, bound to its top level.
`include "top_n_sorted_insert_table_top_defines.svh"

module nsit_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         command_i,
  input logic                         done_o,
  input logic                         inserted_o,
  input logic [nsit_pkg::POS_W-1:0]   insert_position_o,
  input logic                         qualifies_o
);

  // Every accepted transaction gives a result in the next cycle, and only then.
  `NSIT_ASSERT_NEXT(a_done_after_accept, start && !busy, done_o)
  `NSIT_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done_o)
  // An inserted entry always qualified against the last slot.
  `NSIT_ASSERT_NOW(a_insert_qualifies, done_o && inserted_o, qualifies_o)
  // A rejected or read transaction reports slot zero.
  `NSIT_ASSERT_NOW(a_pos_zero, done_o && !inserted_o, insert_position_o == '0)
  // A read never inserts.
  `NSIT_ASSERT_NEXT(a_read_no_insert,
                    start && !busy && (command_i == nsit_pkg::CMD_READ), !inserted_o)

endmodule

bind top_n_sorted_insert_table_top nsit_checker u_nsit_checker (.*);

FILE: sim/tb_top_n_sorted_insert_table_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the sorted insertion table: directed rows, random submits and reads.
module tb_top_n_sorted_insert_table_top;
  import nsit_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT  = 1000;

  // One result of the table, field by field.
  typedef struct packed {
    logic               inserted;
    logic [POS_W-1:0]   position;
    logic               qualifies;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
  } table_result_t;

  // One stimulus row; fixed rows carry a typed-in expectation.
  typedef struct packed {
    cmd_e               cmd;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
    logic [INDEX_W-1:0] index;
    logic               fixed;
    table_result_t      want;
  } stim_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  logic                command_i   = 1'b0;
  logic [TAG_W-1:0]    tag_chars_i = '0;
  logic [SCORE_W-1:0]  score_i     = '0;
  logic [INDEX_W-1:0]  index_i     = '0;
  logic                done_o;
  logic                inserted_o;
  logic [POS_W-1:0]    insert_position_o;
  logic                qualifies_o;
  logic [TAG_W-1:0]    read_tag_o;
  logic [SCORE_W-1:0]  read_score_o;

  // Expectation that travels with the row currently on the inputs.
  logic                row_fixed = 1'b0;
  table_result_t       row_want  = '0;

  // Predicted table contents, best entry first.
  logic [SCORE_W-1:0]  board_score [ENTRIES];
  logic [TAG_W-1:0]    board_tag   [ENTRIES];

  table_result_t       pending_table_results [$];
  int                  error_count  = 0;
  int                  quiet_cycles = 0;

  // Directed rows: empty table, extremes, ties, a full table and misses.
  stim_row_t directed_rows [22] = '{
    '{CMD_READ,   24'h000000, 16'h0000, 8'd0,    1'b1, '{1'b0, 6'd0, 1'b1, DASH_TAG, 16'h0}},
    '{CMD_READ,   24'hFFFFFF, 16'h1234, 8'd9,    1'b1, '{1'b0, 6'd0, 1'b1, DASH_TAG, 16'h0}},
    '{CMD_READ,   24'h000000, 16'hFFFF, 8'd10,   1'b1, '{1'b0, 6'd0, 1'b1, DASH_TAG, 16'h0}},
    '{CMD_READ,   24'h000000, 16'h0000, 8'd255,  1'b1, '{1'b0, 6'd0, 1'b1, DASH_TAG, 16'h0}},
    '{CMD_SUBMIT, 24'h414141, 16'h0000, 8'd0,    1'b1, '{1'b1, 6'd0, 1'b1, 24'h0, 16'h0}},
    '{CMD_SUBMIT, 24'hFFFFFF, 16'hFFFF, 8'd255,  1'b1, '{1'b1, 6'd0, 1'b1, 24'h0, 16'h0}},
    '{CMD_READ,   24'h000000, 16'h0000, 8'd0,    1'b1, '{1'b0, 6'd0, 1'b1, 24'hFFFFFF, 16'hFFFF}},
    '{CMD_READ,   24'h000000, 16'h0000, 8'd1,    1'b1, '{1'b0, 6'd0, 1'b1, 24'h414141, 16'h0}},
    '{CMD_SUBMIT, 24'h000000, 16'h8000, 8'd3,    1'b0, '0},
    '{CMD_SUBMIT, 24'h544945, 16'hFFFF, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h123456, 16'h7000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h234567, 16'h6000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h345678, 16'h5000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h456789, 16'h4000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h56789A, 16'h3000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h6789AB, 16'h2000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h789ABC, 16'h1000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'hAAAAAA, 16'h0FFF, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h555555, 16'h1000, 8'd0,    1'b0, '0},
    '{CMD_SUBMIT, 24'h000000, 16'h0000, 8'd0,    1'b0, '0},
    '{CMD_READ,   24'h000000, 16'h0FFF, 8'd9,    1'b0, '0},
    '{CMD_READ,   24'h000000, 16'h0000, 8'd200,  1'b0, '0}
  };

  top_n_sorted_insert_table_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .command_i         (command_i),
    .tag_chars_i       (tag_chars_i),
    .score_i           (score_i),
    .index_i           (index_i),
    .done_o            (done_o),
    .inserted_o        (inserted_o),
    .insert_position_o (insert_position_o),
    .qualifies_o       (qualifies_o),
    .read_tag_o        (read_tag_o),
    .read_score_o      (read_score_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Prints one mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Applies one transaction to the predicted table and returns its result.
  task automatic score_table_step(input cmd_e cmd, input logic [TAG_W-1:0] tag,
                                  input logic [SCORE_W-1:0] score,
                                  input logic [INDEX_W-1:0] index,
                                  output table_result_t res);
    int  slot;
    bit  found;
    res       = '0;
    res.qualifies = (score >= board_score[ENTRIES-1]);
    if (cmd == CMD_SUBMIT) begin
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && score >= board_score[i]) begin
          found = 1'b1;
          slot  = i;
        end
      end
      if (found) begin
        // Lower entries move down one slot; the last one drops off.
        for (int i = ENTRIES - 1; i > slot; i--) begin
          board_score[i] = board_score[i-1];
          board_tag[i]   = board_tag[i-1];
        end
        board_score[slot] = score;
        board_tag[slot]   = tag;
        res.inserted = 1'b1;
        res.position = slot[POS_W-1:0];
      end
    end else if (index < ENTRIES) begin
      res.tag   = board_tag[index];
      res.score = board_score[index];
    end else begin
      res.tag   = DASH_TAG;
      res.score = '0;
    end
  endtask

  // Puts one row on the inputs, with random idle cycles ahead of it when may_idle is set.
  task automatic drive_transaction(input stim_row_t row, input bit may_idle);
    bit stalled;
    while (may_idle && $urandom_range(0, 99) < 32) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    command_i   <= row.cmd;
    tag_chars_i <= row.tag;
    score_i     <= row.score;
    index_i     <= row.index;
    row_fixed   <= row.fixed;
    row_want    <= row.want;
    do begin
      @(negedge clk_i);
      stalled = (busy !== 1'b0);
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_table_results.size() != 0);
  endtask

  // Picks a score: extremes, uniform, ties with stored entries or near misses.
  function automatic logic [SCORE_W-1:0] pick_score();
    logic [SCORE_W-1:0] s;
    case ($urandom_range(0, 9))
      0:       s = '0;
      1:       s = '1;
      2, 3:    s = SCORE_W'($urandom_range(0, 65535));
      4, 5, 6: s = board_score[$urandom_range(0, ENTRIES - 1)];
      default: s = SCORE_W'(board_score[$urandom_range(0, ENTRIES - 1)]
                            + $urandom_range(0, 64) - 32);
    endcase
    return s;
  endfunction

  // Result check, prediction and watchdog, sampled mid-cycle.
  always @(negedge clk_i) begin : check_results
    table_result_t model_res;
    table_result_t want;
    bit            taken;
    bit            shown;
    if (rst_ni) begin
      taken = start && (busy === 1'b0);
      shown = (done_o === 1'b1);
      if (shown) begin
        if (pending_table_results.size() == 0) begin
          report_mismatch("result with no transaction pending", 32'd0, 32'd0);
        end else begin
          want = pending_table_results.pop_front();
          if (inserted_o !== want.inserted)
            report_mismatch("inserted", 32'(inserted_o), 32'(want.inserted));
          if (insert_position_o !== want.position)
            report_mismatch("insert_position", 32'(insert_position_o), 32'(want.position));
          if (qualifies_o !== want.qualifies)
            report_mismatch("qualifies", 32'(qualifies_o), 32'(want.qualifies));
          if (read_tag_o !== want.tag)
            report_mismatch("read_tag", 32'(read_tag_o), 32'(want.tag));
          if (read_score_o !== want.score)
            report_mismatch("read_score", 32'(read_score_o), 32'(want.score));
        end
      end
      // The transaction taken at the coming edge is predicted after the check.
      if (taken) begin
        score_table_step(cmd_e'(command_i), tag_chars_i, score_i, index_i, model_res);
        pending_table_results.push_back(row_fixed ? row_want : model_res);
      end
      if (taken || shown) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then random transactions.
  initial begin : stimulus
    stim_row_t row;
    bit        calm;
    for (int i = 0; i < ENTRIES; i++) begin
      board_score[i] = '0;
      board_tag[i]   = DASH_TAG;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) drive_transaction(directed_rows[i], 1'b1);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A long stretch runs without idle cycles.
      calm      = (n >= 150 && n < 250);
      row       = '0;
      row.tag   = TAG_W'($urandom_range(0, 24'hFFFFFF));
      row.score = pick_score();
      if ($urandom_range(0, 99) < 55) begin
        row.cmd   = CMD_SUBMIT;
        row.index = INDEX_W'($urandom_range(0, 255));
      end else begin
        row.cmd = CMD_READ;
        case ($urandom_range(0, 3))
          0, 1:    row.index = INDEX_W'($urandom_range(0, ENTRIES - 1));
          2:       row.index = INDEX_W'($urandom_range(ENTRIES, 255));
          default: row.index = INDEX_W'($urandom_range(0, 255));
        endcase
      end
      drive_transaction(row, !calm);
      if (n == 100 || n == 320) drain_results();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/nsit_pkg.sv
rtl/core/nsit_cell.sv
rtl/core/top_n_sorted_insert_table_top.sv
rtl/core/nsit_checker.sv
sim/tb_top_n_sorted_insert_table_top.sv
